FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SNH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SNH_ASSERT_ASYNC(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SNH_ASSERT(lbl, prop, msg)
`define SNH_ASSERT_ASYNC(lbl, prop, msg)
`endif
`endif

FILE: design/snh_pkg.sv
package snh_pkg;
	typedef logic signed [31:0] fix_t;
	typedef logic signed [40:0] cof_t;
	typedef logic signed [42:0] nrm_t;
	typedef logic signed [62:0] prd_t;
	typedef logic signed [47:0] res_t;

	typedef fix_t fmat_t [9];
	typedef cof_t cmat_t [9];
	typedef prd_t pmat_t [9];
	typedef res_t rmat_t [9];

	localparam int MUL_SPLIT = 32;
	localparam int MUL_LAT = 4;
	localparam int FRAC = 24;
	localparam int COEF_FRAC = 16;
	localparam logic [61:0] MAG_LIM = '1;

	localparam logic [1:0] REG_SHEAR = 2'd0;
	localparam logic [1:0] REG_VOLUME = 2'd1;
	localparam logic [1:0] REG_ALPHA = 2'd2;
endpackage

FILE: design/stable_neo_hookean_stress.sv
// Stable Neo-Hookean energy and first Piola-Kirchhoff stress for one 3x3 deformation
// gradient (Q8.24) per word. The block is a fixed 20-stage pipeline with no stall path: busy
// is always low, a word is taken at every clock edge where start is high, and its energy and
// stress (Q24.24, saturated to 48 bits) appear on the result ports at the end of the pipeline,
// marked by done for one cycle. The receiver must take each result in that cycle; nothing is
// held back. The latency is set by the chain determinant -> volume term k -> k times the
// cofactors, each step a four-stage split multiplier. Write shear_modulus, volume_modulus and
// rest_volume_offset only while no word is in flight; they take effect on the next word.
`include "assert_macros.svh"

module stable_neo_hookean_stress (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input snh_pkg::fix_t f_00,
	input snh_pkg::fix_t f_01,
	input snh_pkg::fix_t f_02,
	input snh_pkg::fix_t f_10,
	input snh_pkg::fix_t f_11,
	input snh_pkg::fix_t f_12,
	input snh_pkg::fix_t f_20,
	input snh_pkg::fix_t f_21,
	input snh_pkg::fix_t f_22,
	output logic done,
	output snh_pkg::res_t energy,
	output snh_pkg::res_t p_00,
	output snh_pkg::res_t p_01,
	output snh_pkg::res_t p_02,
	output snh_pkg::res_t p_10,
	output snh_pkg::res_t p_11,
	output snh_pkg::res_t p_12,
	output snh_pkg::res_t p_20,
	output snh_pkg::res_t p_21,
	output snh_pkg::res_t p_22,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [31:0] cfg_data
);
	import snh_pkg::*;

	localparam int S_C = 4;
	localparam int S_S = S_C + 1;
	localparam int S_DET = S_C + MUL_LAT;
	localparam int S_DM = S_DET + 1;
	localparam int S_K = S_DM + MUL_LAT;
	localparam int S_OUT = S_K + MUL_LAT + 3;
	localparam int F_DLY = S_K - S_C;
	localparam int S_DLY = S_K - S_S;
	localparam int DM_DLY = S_K - S_DM;
	localparam int FW = $bits(fix_t);
	localparam int CW = $bits(cof_t);
	localparam int NW = $bits(nrm_t);
	localparam int PRW = $bits(prd_t);
	localparam int DTW = 48;
	localparam int DMW = 50;
	localparam int KW = 33;

	localparam logic [31:0] SHEAR_RST = 32'd65536;
	localparam logic [31:0] VOLUME_RST = 32'd131072;
	localparam logic [30:0] ALPHA_RST = 31'd25165824;

	logic [31:0] shear_q, volume_q;
	logic [30:0] alpha_q;
	logic [S_OUT-1:0] vld_s;

	fmat_t f_in, f_s4;
	cmat_t c_s4;
	nrm_t s_s5;
	logic signed [DTW-1:0] det_s8 [3];
	logic signed [DMW-1:0] dm_s9;

	fmat_t f_dly_s [F_DLY];
	cmat_t c_dly_s [F_DLY];
	nrm_t s_dly_s [S_DLY];
	logic signed [DMW-1:0] dm_dly_s [DM_DLY];

	logic signed [KW-1:0] mu_x, lam_x;
	prd_t k_s13, kd_s17, mus_s17;
	pmat_t mf_s17, kc_s17;
	res_t energy_o;
	rmat_t p_o;

	assign f_in[0] = f_00;
	assign f_in[1] = f_01;
	assign f_in[2] = f_02;
	assign f_in[3] = f_10;
	assign f_in[4] = f_11;
	assign f_in[5] = f_12;
	assign f_in[6] = f_20;
	assign f_in[7] = f_21;
	assign f_in[8] = f_22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shear_q <= SHEAR_RST;
			volume_q <= VOLUME_RST;
			alpha_q <= ALPHA_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SHEAR: begin
					shear_q <= cfg_data;
				end
				REG_VOLUME: begin
					volume_q <= cfg_data;
				end
				REG_ALPHA: begin
					alpha_q <= cfg_data[30:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[S_OUT-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_s[S_OUT-1];

	snh_cofac u_front (
		.clk(clk),
		.f_in(f_in),
		.f_s4(f_s4),
		.c_s4(c_s4),
		.s_s5(s_s5)
	);

	generate
		for (genvar r = 0; r < 3; r++) begin : g_det
			snh_mulr #(.AW(FW), .BW(CW), .SHIFT(FRAC), .OW(DTW)) u_det (
				.clk(clk),
				.a(f_s4[3 * r]),
				.b(c_s4[3 * r]),
				.y(det_s8[r])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		dm_s9 <= DMW'(det_s8[0]) + DMW'(det_s8[1]) + DMW'(det_s8[2])
			- DMW'($signed({1'b0, alpha_q}));

		f_dly_s[0] <= f_s4;
		c_dly_s[0] <= c_s4;
		for (int i = 1; i < F_DLY; i++) begin
			f_dly_s[i] <= f_dly_s[i-1];
			c_dly_s[i] <= c_dly_s[i-1];
		end
		s_dly_s[0] <= s_s5;
		for (int i = 1; i < S_DLY; i++) begin
			s_dly_s[i] <= s_dly_s[i-1];
		end
		dm_dly_s[0] <= dm_s9;
		for (int i = 1; i < DM_DLY; i++) begin
			dm_dly_s[i] <= dm_dly_s[i-1];
		end
	end

	assign mu_x = $signed({1'b0, shear_q});
	assign lam_x = $signed({1'b0, volume_q});

	snh_mulr #(.AW(KW), .BW(DMW), .SHIFT(COEF_FRAC), .OW(PRW)) u_k (
		.clk(clk),
		.a(lam_x),
		.b(dm_s9),
		.y(k_s13)
	);

	snh_mulr #(.AW(PRW), .BW(DMW), .SHIFT(FRAC), .OW(PRW)) u_kd (
		.clk(clk),
		.a(k_s13),
		.b(dm_dly_s[DM_DLY-1]),
		.y(kd_s17)
	);

	snh_mulr #(.AW(KW), .BW(NW), .SHIFT(COEF_FRAC), .OW(PRW)) u_mus (
		.clk(clk),
		.a(mu_x),
		.b(s_dly_s[S_DLY-1]),
		.y(mus_s17)
	);

	generate
		for (genvar i = 0; i < 9; i++) begin : g_stress
			snh_mulr #(.AW(PRW), .BW(CW), .SHIFT(FRAC), .OW(PRW)) u_kc (
				.clk(clk),
				.a(k_s13),
				.b(c_dly_s[F_DLY-1][i]),
				.y(kc_s17[i])
			);
			snh_mulr #(.AW(KW), .BW(FW), .SHIFT(COEF_FRAC), .OW(PRW)) u_mf (
				.clk(clk),
				.a(mu_x),
				.b(f_dly_s[F_DLY-1][i]),
				.y(mf_s17[i])
			);
		end
	endgenerate

	snh_outsat u_out (
		.clk(clk),
		.ld(vld_s[S_OUT-2]),
		.mus(mus_s17),
		.kd(kd_s17),
		.mf(mf_s17),
		.kc(kc_s17),
		.energy(energy_o),
		.p(p_o)
	);

	assign energy = energy_o;
	assign p_00 = p_o[0];
	assign p_01 = p_o[1];
	assign p_02 = p_o[2];
	assign p_10 = p_o[3];
	assign p_11 = p_o[4];
	assign p_12 = p_o[5];
	assign p_20 = p_o[6];
	assign p_21 = p_o[7];
	assign p_22 = p_o[8];

	`SNH_ASSERT(a_latency, done |-> $past(start, S_OUT), "result strobe without a word taken")
	`SNH_ASSERT_ASYNC(a_rst_quiet, !arst_n |-> !done, "result strobe during reset")
endmodule

FILE: design/snh_mulr.sv
module snh_mulr #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int SHIFT = 16,
	parameter int OW = 63
) (
	input logic clk,
	input logic signed [AW-1:0] a,
	input logic signed [BW-1:0] b,
	output logic signed [OW-1:0] y
);
	import snh_pkg::*;

	localparam int ALW = (AW > MUL_SPLIT) ? MUL_SPLIT : AW;
	localparam int AHW = (AW > MUL_SPLIT) ? AW - MUL_SPLIT : 1;
	localparam int BLW = (BW > MUL_SPLIT) ? MUL_SPLIT : BW;
	localparam int BHW = (BW > MUL_SPLIT) ? BW - MUL_SPLIT : 1;
	localparam int PW = AW + BW + 1;
	localparam logic [PW-1:0] HALF = PW'(1) << (SHIFT - 1);

	logic [AW-1:0] am_s1;
	logic [BW-1:0] bm_s1;
	logic neg_s1, neg_s2, neg_s3;
	logic [ALW-1:0] a_lo;
	logic [AHW-1:0] a_hi;
	logic [BLW-1:0] b_lo;
	logic [BHW-1:0] b_hi;
	logic [ALW+BLW-1:0] pp_ll_s2;
	logic [ALW+BHW-1:0] pp_lh_s2;
	logic [AHW+BLW-1:0] pp_hl_s2;
	logic [AHW+BHW-1:0] pp_hh_s2;
	logic [PW-1:0] sum_s3;
	logic [PW-1:0] shifted;
	logic [61:0] mag;
	logic signed [62:0] res;
	logic signed [OW-1:0] y_s4;

	generate
		if (AW > MUL_SPLIT) begin : g_asplit
			assign a_lo = am_s1[MUL_SPLIT-1:0];
			assign a_hi = am_s1[AW-1:MUL_SPLIT];
		end else begin : g_anarrow
			assign a_lo = am_s1;
			assign a_hi = '0;
		end
		if (BW > MUL_SPLIT) begin : g_bsplit
			assign b_lo = bm_s1[MUL_SPLIT-1:0];
			assign b_hi = bm_s1[BW-1:MUL_SPLIT];
		end else begin : g_bnarrow
			assign b_lo = bm_s1;
			assign b_hi = '0;
		end
	endgenerate

	always_comb begin
		shifted = sum_s3 >> SHIFT;
		mag = (shifted > PW'(MAG_LIM)) ? MAG_LIM : shifted[61:0];
		res = neg_s3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_ff @(posedge clk) begin
		am_s1 <= a[AW-1] ? $unsigned(-a) : $unsigned(a);
		bm_s1 <= b[BW-1] ? $unsigned(-b) : $unsigned(b);
		neg_s1 <= a[AW-1] ^ b[BW-1];

		pp_ll_s2 <= a_lo * b_lo;
		pp_lh_s2 <= a_lo * b_hi;
		pp_hl_s2 <= a_hi * b_lo;
		pp_hh_s2 <= a_hi * b_hi;
		neg_s2 <= neg_s1;

		sum_s3 <= PW'(pp_ll_s2) + (PW'(pp_lh_s2) << MUL_SPLIT) + (PW'(pp_hl_s2) << MUL_SPLIT)
			+ (PW'(pp_hh_s2) << (2 * MUL_SPLIT)) + HALF;
		neg_s3 <= neg_s2;

		y_s4 <= res[OW-1:0];
	end

	assign y = y_s4;
endmodule

FILE: design/snh_cofac.sv
module snh_cofac (
	input logic clk,
	input snh_pkg::fmat_t f_in,
	output snh_pkg::fmat_t f_s4,
	output snh_pkg::cmat_t c_s4,
	output snh_pkg::nrm_t s_s5
);
	import snh_pkg::*;

	localparam logic [64:0] RND_POS = 65'(1) << (FRAC - 1);
	localparam logic [64:0] RND_NEG = RND_POS - 65'd1;
	localparam logic [62:0] SQ_HALF = 63'(1) << (FRAC - 1);
	localparam logic [42:0] THREE_ONE = 43'(3) << FRAC;

	fmat_t f_s1, f_s2, f_s3;
	logic signed [63:0] pa_s2 [9];
	logic signed [63:0] pb_s2 [9];
	logic signed [63:0] cd_s3 [9];
	logic [62:0] sq_s2 [9];
	logic [38:0] sqr_s3 [9];
	logic [40:0] row_s4 [3];

	always_ff @(posedge clk) begin
		f_s1 <= f_in;
		f_s2 <= f_s1;
		f_s3 <= f_s2;
		f_s4 <= f_s3;
	end

	// cofactor column c is the cross product of the next two columns
	generate
		for (genvar r = 0; r < 3; r++) begin : g_row
			for (genvar c = 0; c < 3; c++) begin : g_col
				localparam int A = (c + 1) % 3;
				localparam int B = (c + 2) % 3;
				localparam int R1 = (r + 1) % 3;
				localparam int R2 = (r + 2) % 3;
				localparam int I = 3 * r + c;
				logic signed [63:0] sqw;
				logic [62:0] rs;
				logic [64:0] rnd;

				assign sqw = f_s1[I] * f_s1[I];
				assign rs = sq_s2[I] + SQ_HALF;
				assign rnd = {cd_s3[I][63], cd_s3[I]} + (cd_s3[I][63] ? RND_NEG : RND_POS);

				always_ff @(posedge clk) begin
					pa_s2[I] <= f_s1[3 * R1 + A] * f_s1[3 * R2 + B];
					pb_s2[I] <= f_s1[3 * R2 + A] * f_s1[3 * R1 + B];
					sq_s2[I] <= sqw[62:0];
					cd_s3[I] <= pa_s2[I] - pb_s2[I];
					sqr_s3[I] <= rs[62:FRAC];
					c_s4[I] <= rnd[64:FRAC];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			row_s4[r] <= 41'(sqr_s3[3 * r]) + 41'(sqr_s3[3 * r + 1]) + 41'(sqr_s3[3 * r + 2]);
		end
		s_s5 <= $signed(43'(row_s4[0]) + 43'(row_s4[1]) + 43'(row_s4[2]) - THREE_ONE);
	end
endmodule

FILE: design/snh_outsat.sv
module snh_outsat (
	input logic clk,
	input logic ld,
	input snh_pkg::prd_t mus,
	input snh_pkg::prd_t kd,
	input snh_pkg::pmat_t mf,
	input snh_pkg::pmat_t kc,
	output snh_pkg::res_t energy,
	output snh_pkg::rmat_t p
);
	import snh_pkg::*;

	localparam logic signed [63:0] RES_MAX = 64'sh0000_7fff_ffff_ffff;
	localparam logic signed [63:0] RES_MIN = -RES_MAX - 64'sd1;

	function automatic res_t sat48(input logic signed [63:0] x);
		res_t v;
		if (x > RES_MAX) begin
			v = RES_MAX[47:0];
		end else if (x < RES_MIN) begin
			v = RES_MIN[47:0];
		end else begin
			v = x[47:0];
		end
		return v;
	endfunction

	logic signed [63:0] e_s18, er_s19;
	logic signed [63:0] ps_s18 [9];
	res_t pq_s19 [9];
	res_t energy_s20;
	rmat_t p_s20;

	always_ff @(posedge clk) begin
		e_s18 <= 64'(mus) + 64'(kd);
		// halve with ties away from zero
		er_s19 <= e_s18[63] ? (e_s18 >>> 1) : ((e_s18 + 64'sd1) >>> 1);
		for (int i = 0; i < 9; i++) begin
			ps_s18[i] <= 64'(mf[i]) + 64'(kc[i]);
			pq_s19[i] <= sat48(ps_s18[i]);
		end
		if (ld) begin
			energy_s20 <= sat48(er_s19);
			p_s20 <= pq_s19;
		end
	end

	assign energy = energy_s20;
	assign p = p_s20;
endmodule
